/* sv/machine_trap_entry_unit_assert.svh */
// Assertion macros for the trap entry unit.
`ifndef MACHINE_TRAP_ENTRY_UNIT_ASSERT_SVH
`define MACHINE_TRAP_ENTRY_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// Checked at every rising clock edge, skipped while reset is asserted.
`define MTE_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("mte assertion failed");
// Checked at every rising clock edge, reset included.
`define MTE_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) (prop)) \
    else $error("mte assertion failed");
`else
`define MTE_ASSERT(name, clk, rst_n, prop)
`define MTE_ASSERT_ALWAYS(name, clk, prop)
`endif

`endif

/* sv/mte_pkg.sv */
package mte_pkg;

  localparam int unsigned CauseW = 14;
  localparam int unsigned CauseIdxW = 4;
  localparam int unsigned XLen = 32;
  localparam int unsigned CsrAddrW = 12;
  localparam int unsigned CodeW = 5;
  localparam int unsigned ModeW = 2;

  // Flag positions in cause_flags
  localparam logic [CauseIdxW-1:0] FlagBusErr        = 4'd0;
  localparam logic [CauseIdxW-1:0] FlagEcallBadMode  = 4'd1;
  localparam logic [CauseIdxW-1:0] FlagMret          = 4'd2;
  localparam logic [CauseIdxW-1:0] FlagStoreFault    = 4'd3;
  localparam logic [CauseIdxW-1:0] FlagLoadFault     = 4'd4;
  localparam logic [CauseIdxW-1:0] FlagStoreMisalign = 4'd5;
  localparam logic [CauseIdxW-1:0] FlagLoadMisalign  = 4'd6;
  localparam logic [CauseIdxW-1:0] FlagEcallM        = 4'd7;
  localparam logic [CauseIdxW-1:0] FlagEcallS        = 4'd8;
  localparam logic [CauseIdxW-1:0] FlagEcallU        = 4'd9;
  localparam logic [CauseIdxW-1:0] FlagBreak         = 4'd10;
  localparam logic [CauseIdxW-1:0] FlagFetchMisalign = 4'd11;
  localparam logic [CauseIdxW-1:0] FlagIllegal       = 4'd12;
  localparam logic [CauseIdxW-1:0] FlagFetchFault    = 4'd13;

  // Privilege modes
  localparam logic [ModeW-1:0] ModeUser    = 2'd0;
  localparam logic [ModeW-1:0] ModeMachine = 2'd3;

  // mcause codes
  localparam logic [CodeW-1:0] CodeFetchMisalign = 5'd0;
  localparam logic [CodeW-1:0] CodeFetchFault    = 5'd1;
  localparam logic [CodeW-1:0] CodeIllegal       = 5'd2;
  localparam logic [CodeW-1:0] CodeBreakpoint    = 5'd3;
  localparam logic [CodeW-1:0] CodeLoadMisalign  = 5'd4;
  localparam logic [CodeW-1:0] CodeLoadFault     = 5'd5;
  localparam logic [CodeW-1:0] CodeStoreMisalign = 5'd6;
  localparam logic [CodeW-1:0] CodeStoreFault    = 5'd7;
  localparam logic [CodeW-1:0] CodeEcallU        = 5'd8;
  localparam logic [CodeW-1:0] CodeEcallS        = 5'd9;
  localparam logic [CodeW-1:0] CodeEcallM        = 5'd11;
  localparam logic [CodeW-1:0] CodeEcallBadMode  = 5'd24;

  // mstatus fields touched on trap entry and return
  localparam int unsigned StSaveBit  = 31;
  localparam int unsigned StPrevHi   = 12;
  localparam int unsigned StPrevLo   = 11;
  localparam int unsigned StPrevIeBit = 7;
  localparam int unsigned StIeBit    = 3;

  typedef enum logic [1:0] {
    TV_ZERO,
    TV_EXEC,
    TV_PC,
    TV_BRANCH
  } tval_sel_e;

  typedef struct packed {
    logic [CodeW-1:0] code;
    tval_sel_e        tval_sel;
    logic             save;
  } trap_entry_t;

  typedef enum logic [2:0] {
    ACT_QUIET,   // no exception anywhere: pass CSR write on
    ACT_TRAP,    // take a trap
    ACT_MRET,    // return from machine mode
    ACT_NOFLAG,  // exception but no flag: clear mret only
    ACT_HOLD     // sibling stage wins: hold everything
  } action_e;

  typedef struct packed {
    action_e          action;
    logic             stage_exc;
    logic             any_exc;
    logic [XLen-1:0]  status;
    logic [CodeW-1:0] cause;
    logic [XLen-1:0]  tval;
  } dec_t;

  function automatic trap_entry_t trap_entry(input logic [CauseIdxW-1:0] idx);
    trap_entry_t e;
    e = '{code: CodeFetchMisalign, tval_sel: TV_ZERO, save: 1'b0};
    unique case (idx)
      FlagBusErr:        e = '{code: CodeLoadFault,     tval_sel: TV_EXEC,   save: 1'b0};
      FlagEcallBadMode:  e = '{code: CodeEcallBadMode,  tval_sel: TV_ZERO,   save: 1'b0};
      FlagStoreFault:    e = '{code: CodeStoreFault,    tval_sel: TV_EXEC,   save: 1'b0};
      FlagLoadFault:     e = '{code: CodeLoadFault,     tval_sel: TV_EXEC,   save: 1'b0};
      FlagStoreMisalign: e = '{code: CodeStoreMisalign, tval_sel: TV_EXEC,   save: 1'b0};
      FlagLoadMisalign:  e = '{code: CodeLoadMisalign,  tval_sel: TV_EXEC,   save: 1'b0};
      FlagEcallM:        e = '{code: CodeEcallM,        tval_sel: TV_ZERO,   save: 1'b1};
      FlagEcallS:        e = '{code: CodeEcallS,        tval_sel: TV_ZERO,   save: 1'b1};
      FlagEcallU:        e = '{code: CodeEcallU,        tval_sel: TV_ZERO,   save: 1'b1};
      FlagBreak:         e = '{code: CodeBreakpoint,    tval_sel: TV_PC,     save: 1'b1};
      FlagFetchMisalign: e = '{code: CodeFetchMisalign, tval_sel: TV_BRANCH, save: 1'b0};
      FlagIllegal:       e = '{code: CodeIllegal,       tval_sel: TV_ZERO,   save: 1'b0};
      FlagFetchFault:    e = '{code: CodeFetchFault,    tval_sel: TV_ZERO,   save: 1'b0};
      default:           e = '{code: CodeFetchMisalign, tval_sel: TV_ZERO,   save: 1'b0};
    endcase
    return e;
  endfunction

  function automatic logic [XLen-1:0] build_status(input logic [XLen-1:0]  st,
                                                   input logic             save,
                                                   input logic [ModeW-1:0] prior,
                                                   input logic             ie);
    logic [XLen-1:0] r;
    r = st;
    r[StSaveBit] = save;
    r[StPrevHi:StPrevLo] = prior;
    r[StPrevIeBit] = st[StIeBit];
    r[StIeBit] = ie;
    return r;
  endfunction

endpackage

/* sv/machine_trap_entry_unit.sv */
// Channel | Direction | Handshake                  | Payload
// in      | request   | in_valid_i / in_stall_o    | cause_flags_i .. csr_target_i
// out     | result    | out_valid_o / out_stall_i  | any_exception_o .. privilege_mode_o
//
// Throughput: one request per cycle unless the output stalls. Two registers:
// input, then result; the trap decision sits between the two registers.
// Reset (rst_ni low, async): no request held, mode = machine, all held trap
// and CSR outputs zero.
// A stall on the output stops the result register; the input register keeps
// taking a request as long as the one it holds can move on in the same cycle.
`include "machine_trap_entry_unit_assert.svh"

module machine_trap_entry_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // request channel
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [mte_pkg::CauseW-1:0]   cause_flags_i,
  input  logic                         exception_in_i,
  input  logic                         sibling_exception_i,
  input  logic                         this_stage_priority_i,
  input  logic [mte_pkg::XLen-1:0]     status_now_i,
  input  logic [mte_pkg::XLen-1:0]     instr_pc_i,
  input  logic [mte_pkg::XLen-1:0]     exec_result_i,
  input  logic [mte_pkg::XLen-1:0]     branch_target_i,
  input  logic [mte_pkg::XLen-1:0]     saved_epc_i,
  input  logic                         csr_write_request_i,
  input  logic [mte_pkg::CsrAddrW-1:0] csr_target_i,
  // result channel
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         any_exception_o,
  output logic                         stage_exception_o,
  output logic                         csr_write_valid_o,
  output logic [mte_pkg::CsrAddrW-1:0] csr_write_addr_o,
  output logic [mte_pkg::XLen-1:0]     csr_write_value_o,
  output logic [mte_pkg::XLen-1:0]     status_next_o,
  output logic [mte_pkg::XLen-1:0]     epc_next_o,
  output logic [mte_pkg::CodeW-1:0]    cause_code_o,
  output logic [mte_pkg::XLen-1:0]     trap_value_o,
  output logic [mte_pkg::XLen-1:0]     return_target_o,
  output logic                         mret_taken_o,
  output logic [mte_pkg::ModeW-1:0]    privilege_mode_o
);

  // ---------------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------------
  logic                         in_valid_q, in_valid_d;
  logic [mte_pkg::CauseW-1:0]   flags_q;
  logic                         exc_in_q;
  logic                         sib_q;
  logic                         prio_q;
  logic [mte_pkg::XLen-1:0]     status_q;
  logic [mte_pkg::XLen-1:0]     pc_q;
  logic [mte_pkg::XLen-1:0]     res_q;
  logic [mte_pkg::XLen-1:0]     btgt_q;
  logic [mte_pkg::XLen-1:0]     epc_in_q;
  logic                         csr_req_q;
  logic [mte_pkg::CsrAddrW-1:0] csr_adr_q;

  logic out_valid_q, out_valid_d;
  logic advance;   // request in the input register may move to the result side
  logic fire;      // it does move this cycle
  logic load_in;

  assign advance    = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;
  assign load_in    = in_valid_i && !in_stall_o;

  assign in_valid_d  = load_in || (in_valid_q && !advance);
  assign out_valid_d = fire || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_in) begin
      flags_q   <= cause_flags_i;
      exc_in_q  <= exception_in_i;
      sib_q     <= sibling_exception_i;
      prio_q    <= this_stage_priority_i;
      status_q  <= status_now_i;
      pc_q      <= instr_pc_i;
      res_q     <= exec_result_i;
      btgt_q    <= branch_target_i;
      epc_in_q  <= saved_epc_i;
      csr_req_q <= csr_write_request_i;
      csr_adr_q <= csr_target_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Trap decision
  // ---------------------------------------------------------------------------
  // Result registers double as the architectural hold state: an output that a
  // request does not write keeps its last value. They only change on fire,
  // which happens only when the previous result has gone or is going.
  logic [mte_pkg::ModeW-1:0]    mode_q, mode_d;
  logic                         any_exc_q, any_exc_d;
  logic                         stage_exc_q, stage_exc_d;
  logic                         csr_valid_q, csr_valid_d;
  logic [mte_pkg::CsrAddrW-1:0] csr_addr_q, csr_addr_d;
  logic [mte_pkg::XLen-1:0]     csr_value_q, csr_value_d;
  logic [mte_pkg::XLen-1:0]     st_next_q, st_next_d;
  logic [mte_pkg::XLen-1:0]     epc_q, epc_d;
  logic [mte_pkg::CodeW-1:0]    cause_q, cause_d;
  logic [mte_pkg::XLen-1:0]     tval_q, tval_d;
  logic [mte_pkg::XLen-1:0]     ret_q, ret_d;
  logic                         mret_q, mret_d;

  mte_pkg::dec_t dec;

  mte_trap_dec u_dec (
    .cause_flags_i         (flags_q),
    .exception_in_i        (exc_in_q),
    .sibling_exception_i   (sib_q),
    .this_stage_priority_i (prio_q),
    .status_now_i          (status_q),
    .instr_pc_i            (pc_q),
    .exec_result_i         (res_q),
    .branch_target_i       (btgt_q),
    .mode_i                (mode_q),
    .dec_o                 (dec)
  );

  always_comb begin
    mode_d      = mode_q;
    any_exc_d   = dec.any_exc;
    stage_exc_d = dec.stage_exc;
    csr_valid_d = csr_valid_q;
    csr_addr_d  = csr_addr_q;
    csr_value_d = csr_value_q;
    st_next_d   = st_next_q;
    epc_d       = epc_q;
    cause_d     = cause_q;
    tval_d      = tval_q;
    ret_d       = ret_q;
    mret_d      = mret_q;

    unique case (dec.action)
      mte_pkg::ACT_QUIET: begin
        // CSR write goes through; zeros when none is requested
        csr_valid_d = csr_req_q;
        csr_addr_d  = csr_req_q ? csr_adr_q : '0;
        csr_value_d = csr_req_q ? res_q : '0;
        mret_d      = 1'b0;
      end
      mte_pkg::ACT_TRAP: begin
        st_next_d = dec.status;
        epc_d     = pc_q;
        cause_d   = dec.cause;
        tval_d    = dec.tval;
        mode_d    = mte_pkg::ModeMachine;
        mret_d    = 1'b0;
      end
      mte_pkg::ACT_MRET: begin
        // cause holds; enable set, drop to user mode
        st_next_d = dec.status;
        epc_d     = pc_q;
        tval_d    = dec.tval;
        ret_d     = epc_in_q;
        mode_d    = mte_pkg::ModeUser;
        mret_d    = 1'b1;
      end
      mte_pkg::ACT_NOFLAG: begin
        mret_d = 1'b0;
      end
      mte_pkg::ACT_HOLD: begin
        // sibling stage owns the trap: nothing written here
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= mte_pkg::ModeMachine;
      any_exc_q   <= 1'b0;
      stage_exc_q <= 1'b0;
      csr_valid_q <= 1'b0;
      csr_addr_q  <= '0;
      csr_value_q <= '0;
      st_next_q   <= '0;
      epc_q       <= '0;
      cause_q     <= '0;
      tval_q      <= '0;
      ret_q       <= '0;
      mret_q      <= 1'b0;
    end else if (fire) begin
      mode_q      <= mode_d;
      any_exc_q   <= any_exc_d;
      stage_exc_q <= stage_exc_d;
      csr_valid_q <= csr_valid_d;
      csr_addr_q  <= csr_addr_d;
      csr_value_q <= csr_value_d;
      st_next_q   <= st_next_d;
      epc_q       <= epc_d;
      cause_q     <= cause_d;
      tval_q      <= tval_d;
      ret_q       <= ret_d;
      mret_q      <= mret_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Outputs
  // ---------------------------------------------------------------------------
  assign out_valid_o       = out_valid_q;
  assign any_exception_o   = any_exc_q;
  assign stage_exception_o = stage_exc_q;
  assign csr_write_valid_o = csr_valid_q;
  assign csr_write_addr_o  = csr_addr_q;
  assign csr_write_value_o = csr_value_q;
  assign status_next_o     = st_next_q;
  assign epc_next_o        = epc_q;
  assign cause_code_o      = cause_q;
  assign trap_value_o      = tval_q;
  assign return_target_o   = ret_q;
  assign mret_taken_o      = mret_q;
  assign privilege_mode_o  = mode_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // A pending MRET result always goes with user mode.
  `MTE_ASSERT(a_mret_user_mode, clk_i, rst_ni, !mret_q || (mode_q == mte_pkg::ModeUser))
  // Only user (00) and machine (11) modes are ever produced: both bits agree.
  `MTE_ASSERT(a_mode_legal, clk_i, rst_ni, mode_q[1] == mode_q[0])
  // A CSR bundle without a write is all zeros.
  `MTE_ASSERT(a_csr_zero, clk_i, rst_ni, csr_valid_q || (!(|csr_addr_q) && !(|csr_value_q)))
  // Input side only stalls with the result side full and blocked.
  `MTE_ASSERT(a_stall_cause, clk_i, rst_ni, in_stall_o |-> (out_valid_q && out_stall_i))

endmodule

/* sv/mte_trap_dec.sv */
// Decides what one retiring instruction does and builds the trap values.
module mte_trap_dec (
  input  logic [mte_pkg::CauseW-1:0] cause_flags_i,
  input  logic                       exception_in_i,
  input  logic                       sibling_exception_i,
  input  logic                       this_stage_priority_i,
  input  logic [mte_pkg::XLen-1:0]   status_now_i,
  input  logic [mte_pkg::XLen-1:0]   instr_pc_i,
  input  logic [mte_pkg::XLen-1:0]   exec_result_i,
  input  logic [mte_pkg::XLen-1:0]   branch_target_i,
  input  logic [mte_pkg::ModeW-1:0]  mode_i,
  output mte_pkg::dec_t              dec_o
);

  logic                          stage_exc;
  logic                          hit;
  logic [mte_pkg::CauseIdxW-1:0] idx;
  mte_pkg::trap_entry_t          entry;

  assign stage_exc = exception_in_i | cause_flags_i[mte_pkg::FlagBusErr];

  // lowest set flag wins
  always_comb begin
    hit = 1'b0;
    idx = '0;
    for (int i = mte_pkg::CauseW - 1; i >= 0; i--) begin
      if (cause_flags_i[i]) begin
        hit = 1'b1;
        idx = mte_pkg::CauseIdxW'(i);
      end
    end
  end

  assign entry = mte_pkg::trap_entry(idx);

  always_comb begin
    dec_o.stage_exc = stage_exc;
    dec_o.any_exc   = stage_exc | sibling_exception_i;
    dec_o.cause     = entry.code;

    priority if (!stage_exc && !sibling_exception_i) begin
      dec_o.action = mte_pkg::ACT_QUIET;
    end else if (stage_exc && (!sibling_exception_i || this_stage_priority_i)) begin
      if (!hit) begin
        dec_o.action = mte_pkg::ACT_NOFLAG;
      end else if (idx == mte_pkg::FlagMret) begin
        dec_o.action = mte_pkg::ACT_MRET;
      end else begin
        dec_o.action = mte_pkg::ACT_TRAP;
      end
    end else begin
      dec_o.action = mte_pkg::ACT_HOLD;
    end

    if (dec_o.action == mte_pkg::ACT_MRET) begin
      dec_o.status = mte_pkg::build_status(status_now_i, 1'b0, mode_i, 1'b1);
      dec_o.tval   = '0;
    end else begin
      dec_o.status = mte_pkg::build_status(status_now_i, entry.save, mode_i, 1'b0);
      unique case (entry.tval_sel)
        mte_pkg::TV_EXEC:   dec_o.tval = exec_result_i;
        mte_pkg::TV_PC:     dec_o.tval = instr_pc_i;
        mte_pkg::TV_BRANCH: dec_o.tval = branch_target_i;
        default:            dec_o.tval = '0;
      endcase
    end
  end

endmodule

/* tb/tb_machine_trap_entry_unit.sv */
`timescale 1ns / 1ps

module tb_machine_trap_entry_unit;
  import mte_pkg::*;

  localparam int unsigned NumRandom   = 1800;
  localparam int unsigned QuietLimit  = 4000;  // cycles with no handshake on either side
  localparam int unsigned DrainCycles = 8;     // two-stage pipe, plus margin
  localparam int unsigned MaxReported = 10;

  // Bit positions inside cause_flags; lowest set bit decides the trap.
  typedef enum int unsigned {
    FL_BUS_ERR, FL_ECALL_BAD_MODE, FL_MRET, FL_STORE_FAULT, FL_LOAD_FAULT,
    FL_STORE_MISALIGN, FL_LOAD_MISALIGN, FL_ECALL_M, FL_ECALL_S, FL_ECALL_U,
    FL_EBREAK, FL_FETCH_MISALIGN, FL_ILLEGAL, FL_FETCH_FAULT, FL_COUNT
  } flag_bit_e;

  // One retiring instruction as seen by the unit.
  typedef struct {
    logic [CauseW-1:0]   flags;
    logic                exc_in;
    logic                sibling;
    logic                prio;
    logic [XLen-1:0]     status, pc, exec_res, branch_tgt, epc;
    logic                csr_req;
    logic [CsrAddrW-1:0] csr_addr;
  } retire_req_t;

  // Everything the unit hands out for one instruction.
  typedef struct {
    logic                any_exc;
    logic                stage_exc;
    logic                csr_valid;
    logic [CsrAddrW-1:0] csr_addr;
    logic [XLen-1:0]     csr_value, status, epc;
    logic [CodeW-1:0]    cause;
    logic [XLen-1:0]     tval, ret_target;
    logic                mret;
    logic [ModeW-1:0]    mode;
  } retire_outcome_t;

  // Tracks privilege mode and the held trap/CSR outputs, queues the outcome
  // of every accepted request and compares results against it in order.
  class trap_outcome_board;
    logic [ModeW-1:0]    mode;
    logic [XLen-1:0]     status, epc, tval, ret_target, csr_value;
    logic [CodeW-1:0]    cause;
    logic                csr_valid;
    logic [CsrAddrW-1:0] csr_addr;
    logic                mret;
    retire_outcome_t     outcome_q[$];
    int unsigned         errors;
    int unsigned         seen;

    function new();
      mode       = ModeMachine;
      status     = '0;
      epc        = '0;
      tval       = '0;
      ret_target = '0;
      csr_value  = '0;
      cause      = '0;
      csr_valid  = 1'b0;
      csr_addr   = '0;
      mret       = 1'b0;
      errors     = 0;
      seen       = 0;
    endfunction

    function int pending();
      return outcome_q.size();
    endfunction

    function int lowest_flag(logic [CauseW-1:0] f);
      for (int i = 0; i < CauseW; i++) begin
        if (f[i]) return i;
      end
      return -1;
    endfunction

    // save flag, prior mode, prior enable and new enable folded into status
    function logic [XLen-1:0] fold_status(logic [XLen-1:0] st, logic save,
                                          logic [ModeW-1:0] prior, logic ie);
      logic [XLen-1:0] keep;
      keep = ~((XLen'(1) << StSaveBit) | (XLen'(3) << StPrevLo) |
               (XLen'(1) << StPrevIeBit) | (XLen'(1) << StIeBit));
      return (st & keep) | (XLen'(save) << StSaveBit) | (XLen'(prior) << StPrevLo) |
             (XLen'(st[StIeBit]) << StPrevIeBit) | (XLen'(ie) << StIeBit);
    endfunction

    function void note_request(retire_req_t r);
      retire_outcome_t o;
      logic            stage;
      logic [ModeW-1:0] prior;
      int              hit;
      logic [CodeW-1:0] code;
      tval_sel_e       sel;
      logic            save;
      stage = r.exc_in | r.flags[FL_BUS_ERR];
      prior = mode;
      code  = CodeFetchMisalign;
      sel   = TV_ZERO;
      save  = 1'b0;
      if (!stage && !r.sibling) begin
        // nothing faulted: CSR write passes through or is zeroed
        csr_valid = r.csr_req;
        csr_addr  = r.csr_req ? r.csr_addr : '0;
        csr_value = r.csr_req ? r.exec_res : '0;
        mret      = 1'b0;
      end else if (stage && (!r.sibling || r.prio)) begin
        hit = lowest_flag(r.flags);
        if (hit < 0) begin
          mret = 1'b0;  // exception without any flag
        end else if (hit == FL_MRET) begin
          status     = fold_status(r.status, 1'b0, prior, 1'b1);
          mode       = ModeUser;
          ret_target = r.epc;
          epc        = r.pc;
          tval       = '0;
          mret       = 1'b1;
        end else begin
          case (hit)
            FL_BUS_ERR:        begin code = CodeLoadFault;     sel = TV_EXEC;   end
            FL_ECALL_BAD_MODE: begin code = CodeEcallBadMode;  sel = TV_ZERO;   end
            FL_STORE_FAULT:    begin code = CodeStoreFault;    sel = TV_EXEC;   end
            FL_LOAD_FAULT:     begin code = CodeLoadFault;     sel = TV_EXEC;   end
            FL_STORE_MISALIGN: begin code = CodeStoreMisalign; sel = TV_EXEC;   end
            FL_LOAD_MISALIGN:  begin code = CodeLoadMisalign;  sel = TV_EXEC;   end
            FL_ECALL_M: begin code = CodeEcallM;     sel = TV_ZERO; save = 1'b1; end
            FL_ECALL_S: begin code = CodeEcallS;     sel = TV_ZERO; save = 1'b1; end
            FL_ECALL_U: begin code = CodeEcallU;     sel = TV_ZERO; save = 1'b1; end
            FL_EBREAK:  begin code = CodeBreakpoint; sel = TV_PC;   save = 1'b1; end
            FL_FETCH_MISALIGN: begin code = CodeFetchMisalign; sel = TV_BRANCH; end
            FL_ILLEGAL:        begin code = CodeIllegal;       sel = TV_ZERO;   end
            default:           begin code = CodeFetchFault;    sel = TV_ZERO;   end
          endcase
          status = fold_status(r.status, save, prior, 1'b0);
          epc    = r.pc;
          cause  = code;
          case (sel)
            TV_EXEC:   tval = r.exec_res;
            TV_PC:     tval = r.pc;
            TV_BRANCH: tval = r.branch_tgt;
            default:   tval = '0;
          endcase
          mode = ModeMachine;
          mret = 1'b0;
        end
      end
      // sibling wins: nothing updated, held values repeat
      o.any_exc    = stage | r.sibling;
      o.stage_exc  = stage;
      o.csr_valid  = csr_valid;
      o.csr_addr   = csr_addr;
      o.csr_value  = csr_value;
      o.status     = status;
      o.epc        = epc;
      o.cause      = cause;
      o.tval       = tval;
      o.ret_target = ret_target;
      o.mret       = mret;
      o.mode       = mode;
      outcome_q.push_back(o);
    endfunction

    function void compare_field(string fname, logic [XLen-1:0] want, logic [XLen-1:0] got);
      if (got !== want) begin
        errors++;
        if (errors <= MaxReported)
          $display("[%0t] result %0d: %s expected %h, got %h", $time, seen, fname, want, got);
      end
    endfunction

    function void check_result(retire_outcome_t a);
      retire_outcome_t e;
      if (outcome_q.size() == 0) begin
        errors++;
        if (errors <= MaxReported)
          $display("[%0t] result arrived with no request outstanding", $time);
        return;
      end
      e = outcome_q.pop_front();
      seen++;
      compare_field("any_exception",   e.any_exc,    a.any_exc);
      compare_field("stage_exception", e.stage_exc,  a.stage_exc);
      compare_field("csr_write_valid", e.csr_valid,  a.csr_valid);
      compare_field("csr_write_addr",  e.csr_addr,   a.csr_addr);
      compare_field("csr_write_value", e.csr_value,  a.csr_value);
      compare_field("status_next",     e.status,     a.status);
      compare_field("epc_next",        e.epc,        a.epc);
      compare_field("cause_code",      e.cause,      a.cause);
      compare_field("trap_value",      e.tval,       a.tval);
      compare_field("return_target",   e.ret_target, a.ret_target);
      compare_field("mret_taken",      e.mret,       a.mret);
      compare_field("privilege_mode",  e.mode,       a.mode);
    endfunction
  endclass

  // Clock, reset and block ports; every input starts at a known value.
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                in_valid_i          = 1'b0;
  logic                in_stall_o;
  logic [CauseW-1:0]   cause_flags_i       = '0;
  logic                exception_in_i      = 1'b0;
  logic                sibling_exception_i = 1'b0;
  logic                this_stage_priority_i = 1'b0;
  logic [XLen-1:0]     status_now_i        = '0;
  logic [XLen-1:0]     instr_pc_i          = '0;
  logic [XLen-1:0]     exec_result_i       = '0;
  logic [XLen-1:0]     branch_target_i     = '0;
  logic [XLen-1:0]     saved_epc_i         = '0;
  logic                csr_write_request_i = 1'b0;
  logic [CsrAddrW-1:0] csr_target_i        = '0;

  logic                out_valid_o;
  logic                out_stall_i         = 1'b0;
  logic                any_exception_o;
  logic                stage_exception_o;
  logic                csr_write_valid_o;
  logic [CsrAddrW-1:0] csr_write_addr_o;
  logic [XLen-1:0]     csr_write_value_o;
  logic [XLen-1:0]     status_next_o;
  logic [XLen-1:0]     epc_next_o;
  logic [CodeW-1:0]    cause_code_o;
  logic [XLen-1:0]     trap_value_o;
  logic [XLen-1:0]     return_target_o;
  logic                mret_taken_o;
  logic [ModeW-1:0]    privilege_mode_o;

  always #5 clk_i = ~clk_i;

  machine_trap_entry_unit DUT (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .in_valid_i            (in_valid_i),
    .in_stall_o            (in_stall_o),
    .cause_flags_i         (cause_flags_i),
    .exception_in_i        (exception_in_i),
    .sibling_exception_i   (sibling_exception_i),
    .this_stage_priority_i (this_stage_priority_i),
    .status_now_i          (status_now_i),
    .instr_pc_i            (instr_pc_i),
    .exec_result_i         (exec_result_i),
    .branch_target_i       (branch_target_i),
    .saved_epc_i           (saved_epc_i),
    .csr_write_request_i   (csr_write_request_i),
    .csr_target_i          (csr_target_i),
    .out_valid_o           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .any_exception_o       (any_exception_o),
    .stage_exception_o     (stage_exception_o),
    .csr_write_valid_o     (csr_write_valid_o),
    .csr_write_addr_o      (csr_write_addr_o),
    .csr_write_value_o     (csr_write_value_o),
    .status_next_o         (status_next_o),
    .epc_next_o            (epc_next_o),
    .cause_code_o          (cause_code_o),
    .trap_value_o          (trap_value_o),
    .return_target_o       (return_target_o),
    .mret_taken_o          (mret_taken_o),
    .privilege_mode_o      (privilege_mode_o)
  );

  trap_outcome_board board = new();

  retire_req_t retire_stream[$];   // directed requests first, then random ones
  retire_req_t shown_req;          // request currently on the input ports
  int unsigned next_idx      = 0;
  int unsigned accepted_reqs = 0;
  int unsigned quiet_cycles  = 0;

  // Idle pattern by progress through the stream: sender 38% / receiver 78%,
  // then swapped, then a final third with no gaps at all.
  function automatic int unsigned stream_phase(int unsigned idx);
    return (idx * 3) / (retire_stream.size() + 1);
  endfunction

  function automatic int unsigned sender_idle_pct(int unsigned idx);
    case (stream_phase(idx))
      0:       return 38;
      1:       return 78;
      default: return 0;
    endcase
  endfunction

  function automatic int unsigned receiver_idle_pct(int unsigned idx);
    case (stream_phase(idx))
      0:       return 78;
      1:       return 38;
      default: return 0;
    endcase
  endfunction

  function automatic retire_req_t mk_req(logic [CauseW-1:0] flags, logic exc, logic sib,
                                         logic prio, logic [XLen-1:0] st,
                                         logic [XLen-1:0] pc, logic [XLen-1:0] res,
                                         logic [XLen-1:0] tgt, logic [XLen-1:0] epc,
                                         logic csr_req, logic [CsrAddrW-1:0] addr);
    retire_req_t r;
    r.flags      = flags;
    r.exc_in     = exc;
    r.sibling    = sib;
    r.prio       = prio;
    r.status     = st;
    r.pc         = pc;
    r.exec_res   = res;
    r.branch_tgt = tgt;
    r.epc        = epc;
    r.csr_req    = csr_req;
    r.csr_addr   = addr;
    return r;
  endfunction

  // Mostly random words, with zero and all-ones showing up now and then.
  function automatic logic [XLen-1:0] rand_word();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Random request biased toward real sequences: clean retires, traps with a
  // chosen winning flag, MRETs (drive the mode to user and back), sibling
  // contention and some plain noise.
  function automatic retire_req_t rand_req();
    retire_req_t r;
    int unsigned kind;
    int unsigned b;
    logic [CauseW-1:0] upper;
    kind = $urandom_range(0, 99);
    r = mk_req(CauseW'($urandom), $urandom_range(0, 1), 1'b0, $urandom_range(0, 1),
               rand_word(), rand_word(), rand_word(), rand_word(), rand_word(),
               $urandom_range(0, 1), CsrAddrW'($urandom));
    if (kind < 30) begin
      r.flags[FL_BUS_ERR] = 1'b0;
      r.exc_in = 1'b0;
    end else if (kind < 78) begin
      b = (kind < 65) ? $urandom_range(0, FL_COUNT - 1) : FL_MRET;
      upper = CauseW'($urandom) & ~((CauseW'(1) << (b + 1)) - 1);
      r.flags = (CauseW'(1) << b) | ($urandom_range(0, 1) ? upper : '0);
      r.exc_in = (b == FL_BUS_ERR) ? 1'($urandom_range(0, 1)) : 1'b1;
      r.sibling = ($urandom_range(0, 3) == 0);
      r.prio = r.sibling ? ($urandom_range(0, 3) != 0) : 1'($urandom_range(0, 1));
    end else if (kind < 90) begin
      r.sibling = 1'b1;
    end else begin
      r.sibling = $urandom_range(0, 1);
      if ($urandom_range(0, 2) == 0) begin
        r.flags  = '0;
        r.exc_in = 1'b1;
      end
    end
    return r;
  endfunction

  task automatic drive_request(retire_req_t r);
    cause_flags_i         <= r.flags;
    exception_in_i        <= r.exc_in;
    sibling_exception_i   <= r.sibling;
    this_stage_priority_i <= r.prio;
    status_now_i          <= r.status;
    instr_pc_i            <= r.pc;
    exec_result_i         <= r.exec_res;
    branch_target_i       <= r.branch_tgt;
    saved_epc_i           <= r.epc;
    csr_write_request_i   <= r.csr_req;
    csr_target_i          <= r.csr_addr;
  endtask

  // Request side: a presented request stays put until taken; a new one (or
  // a gap) is chosen only once the port is free.
  always @(posedge clk_i) begin
    logic taken;
    if (rst_ni) begin
      taken = in_valid_i && !in_stall_o;
      if (taken) begin
        board.note_request(shown_req);
        accepted_reqs <= accepted_reqs + 1;
      end
      if (!in_valid_i || taken) begin
        if (next_idx < retire_stream.size() &&
            $urandom_range(0, 99) >= sender_idle_pct(next_idx)) begin
          shown_req = retire_stream[next_idx];
          drive_request(shown_req);
          in_valid_i <= 1'b1;
          next_idx   <= next_idx + 1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result side: check whatever is taken, then pick next cycle's stall.
  always @(posedge clk_i) begin
    retire_outcome_t got;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got.any_exc    = any_exception_o;
        got.stage_exc  = stage_exception_o;
        got.csr_valid  = csr_write_valid_o;
        got.csr_addr   = csr_write_addr_o;
        got.csr_value  = csr_write_value_o;
        got.status     = status_next_o;
        got.epc        = epc_next_o;
        got.cause      = cause_code_o;
        got.tval       = trap_value_o;
        got.ret_target = return_target_o;
        got.mret       = mret_taken_o;
        got.mode       = privilege_mode_o;
        board.check_result(got);
      end
      out_stall_i <= ($urandom_range(0, 99) < receiver_idle_pct(next_idx));
    end
  end

  // Watchdog input: cycles since the last handshake on either channel.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic timed_out;
    // Directed opening: extreme fields, CSR pass-through, every flag winning
    // on its own, MRET into user mode and a trap out of it, a fault with no
    // flag, sibling-only, sibling winning, this stage winning, all flags at
    // once (bus error wins) and a held MRET behind a sibling win.
    retire_stream.push_back(mk_req('0, 1'b0, 1'b0, 1'b0, '0, '0, '1, '0, '0,
                                   1'b1, '1));
    retire_stream.push_back(mk_req(14'h3FFE, 1'b0, 1'b0, 1'b1, '1, '1, '0, '1, '1,
                                   1'b0, '0));
    for (int b = 0; b < FL_COUNT; b++) begin
      retire_stream.push_back(mk_req(CauseW'(1) << b, b != FL_BUS_ERR, 1'b0, 1'b0,
                                     (b % 2) ? '1 : '0, 32'h0000_1000 + 4 * b,
                                     32'hA5A5_0000 | b, 32'h8000_0002 + b,
                                     32'h0000_4000 + b, 1'b1, CsrAddrW'(b)));
    end
    retire_stream.push_back(mk_req(CauseW'(1) << FL_MRET, 1'b1, 1'b0, 1'b0, 32'h0000_0008,
                                   32'h0000_2000, '0, '0, 32'hCAFE_0000, 1'b0, '0));
    retire_stream.push_back(mk_req(CauseW'(1) << FL_ECALL_U, 1'b1, 1'b0, 1'b0, '1,
                                   32'h0000_2004, '1, '1, '0, 1'b0, '0));
    retire_stream.push_back(mk_req('0, 1'b1, 1'b0, 1'b0, '1, '1, '1, '1, '1, 1'b1, '1));
    retire_stream.push_back(mk_req(CauseW'(1) << FL_ILLEGAL, 1'b0, 1'b1, 1'b0, '1, '1, '1,
                                   '1, '1, 1'b1, '1));
    retire_stream.push_back(mk_req(CauseW'(1) << FL_STORE_FAULT, 1'b1, 1'b1, 1'b0, '1,
                                   '1, '1, '1, '1, 1'b1, '1));
    retire_stream.push_back(mk_req(CauseW'(1) << FL_LOAD_MISALIGN, 1'b1, 1'b1, 1'b1,
                                   32'h1234_5678, 32'h0000_3000, 32'h0000_3003, '0, '0,
                                   1'b0, '0));
    retire_stream.push_back(mk_req(14'h3FFF, 1'b0, 1'b0, 1'b0, '0, '1, 32'hDEAD_BEEF, '1,
                                   '1, 1'b1, '1));
    retire_stream.push_back(mk_req(CauseW'(1) << FL_MRET, 1'b1, 1'b0, 1'b0, '1,
                                   32'h0000_5000, '0, '0, 32'h0000_6000, 1'b0, '0));
    retire_stream.push_back(mk_req(CauseW'(1) << FL_EBREAK, 1'b1, 1'b1, 1'b0, '0, '0, '0,
                                   '0, '0, 1'b1, 12'h300));
    for (int i = 0; i < NumRandom; i++)
      retire_stream.push_back(rand_req());

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Sampled on the falling edge so the counters are settled.
    timed_out = 1'b0;
    while (!(accepted_reqs == retire_stream.size() && board.pending() == 0) &&
           quiet_cycles < QuietLimit)
      @(negedge clk_i);
    if (quiet_cycles >= QuietLimit)
      timed_out = 1'b1;
    else
      repeat (DrainCycles) @(negedge clk_i);

    if (!timed_out && board.errors == 0 && board.pending() == 0)
      $display("machine_trap_entry_unit verification clean");
    else
      $display("machine_trap_entry_unit verification failed");
    $finish;
  end

endmodule
